/* hdl/rupc_pkg.sv */
package rupc_pkg;

   localparam int DIST_W   = 9;
   localparam int TICK_W   = 16;
   localparam int REMAIN_W = 26;
   localparam int MS_TO_US = 1000;

   // read_status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ECHO_HIGH  = 2'd1;
   localparam logic [1:0] ST_NO_ECHO    = 2'd2;
   localparam logic [1:0] ST_ECHO_LONG  = 2'd3;

   // machine_state codes
   localparam logic [1:0] MS_CYCLE = 2'd1;
   localparam logic [1:0] MS_HOLD  = 2'd2;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_PAUSE_DIST = 3'd0;
   localparam logic [2:0] REG_PAUSE_TIME = 3'd1;
   localparam logic [2:0] REG_MAX_RANGE  = 3'd2;
   localparam logic [2:0] REG_US_PER_CM  = 3'd3;
   localparam logic [2:0] REG_PING_TMO   = 3'd4;

   typedef struct packed {
      logic [9:0]        hold_dist_cm;  // two's complement, bit 9 set = off
      logic [15:0]       hold_len_ms;
      logic [DIST_W-1:0] max_range_cm;
      logic [7:0]        us_per_cm;
      logic [TICK_W-1:0] ping_timeout_us;
   } cfg_type;

   typedef struct packed {
      logic              trig;
      logic              busy;
      logic              done;
      logic [1:0]        status;
      logic [DIST_W-1:0] distance;
   } ranger_res_type;

   typedef struct packed {
      logic hold_req;
      logic start_req;
      logic active;
   } pause_res_type;

endpackage

/* hdl/rupc_if.sv */
interface rupc_req_if;
   logic       valid;
   logic       ready;
   logic       start_read;
   logic       echo_level;
   logic [1:0] machine_state;

   modport source (output valid, start_read, echo_level, machine_state, input ready);
   modport sink   (input valid, start_read, echo_level, machine_state, output ready);
endinterface

interface rupc_rsp_if;
   logic       valid;
   logic       ready;
   logic       trig_level;
   logic       busy_res;
   logic       reading_done;
   logic [8:0] distance_cm;
   logic [1:0] read_status;
   logic       feed_hold_request;
   logic       cycle_start_request;
   logic       pause_in_effect;

   modport source (output valid, trig_level, busy_res, reading_done, distance_cm,
                   read_status, feed_hold_request, cycle_start_request,
                   pause_in_effect, input ready);
   modport sink   (input valid, trig_level, busy_res, reading_done, distance_cm,
                   read_status, feed_hold_request, cycle_start_request,
                   pause_in_effect, output ready);
endinterface

/* hdl/ultrasonic_ranger_pause_control.sv */
// Echo-ranging controller with obstacle pause.
// req_chan carries one beat per microsecond tick: start_read, the sampled
// echo_level and the machine_state. rsp_chan returns exactly one beat per
// request beat: trigger pin level, busy flag, reading_done pulse with
// distance_cm and read_status, feed-hold / cycle-start request pulses and
// the pause flag.
// A beat's result is registered at the edge that accepts it and is on
// rsp_chan after that edge. Throughput is one beat per cycle while the
// receiver takes results; the state update and result are a single pass of
// logic between the state registers and the result register.
// When the receiver stalls, the result register holds its beat and req_chan
// ready drops until it is taken; ready is high whenever the result register
// is empty or being emptied in the same cycle.
// Synchronous reset returns the ranger to idle, clears the pause timer and
// flags, empties the result register and loads register defaults.
// Registers (APB, byte address 4*i): pause distance, pause time (ms),
// max range (cm), us per cm, ping timeout (us). Write only while idle.
module ultrasonic_ranger_pause_control #(
   parameter int TRIG_LOW_US  = 4,
   parameter int TRIG_HIGH_US = 10
) (
   input  logic        clock,
   input  logic        reset,
   rupc_req_if.sink    req_chan,
   rupc_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rupc_pkg::*;

   cfg_type        cfg;
   ranger_res_type rng_res;
   pause_res_type  pse_res;
   logic           advance;
   logic           rsp_valid_ff, rsp_valid_in;

   logic              trig_ff, busy_ff, done_ff, hold_ff, cstart_ff, active_ff;
   logic [1:0]        status_ff;
   logic [DIST_W-1:0] dist_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = req_chan.valid && req_chan.ready;

   rupc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rupc_ranger #(
      .TRIG_LOW_US  (TRIG_LOW_US),
      .TRIG_HIGH_US (TRIG_HIGH_US)
   ) u_ranger (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .start_read (req_chan.start_read),
      .echo_level (req_chan.echo_level),
      .cfg        (cfg),
      .res        (rng_res)
   );

   rupc_pause u_pause (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .done          (rng_res.done),
      .distance      (rng_res.distance),
      .machine_state (req_chan.machine_state),
      .cfg           (cfg),
      .res           (pse_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         trig_ff   <= rng_res.trig;
         busy_ff   <= rng_res.busy;
         done_ff   <= rng_res.done;
         status_ff <= rng_res.status;
         dist_ff   <= rng_res.distance;
         hold_ff   <= pse_res.hold_req;
         cstart_ff <= pse_res.start_req;
         active_ff <= pse_res.active;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.trig_level          = trig_ff;
   assign rsp_chan.busy_res            = busy_ff;
   assign rsp_chan.reading_done        = done_ff;
   assign rsp_chan.distance_cm         = dist_ff;
   assign rsp_chan.read_status         = status_ff;
   assign rsp_chan.feed_hold_request   = hold_ff;
   assign rsp_chan.cycle_start_request = cstart_ff;
   assign rsp_chan.pause_in_effect     = active_ff;

endmodule

/* hdl/rupc_csr.sv */
module rupc_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output rupc_pkg::cfg_type cfg
);
   import rupc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PAUSE_DIST: cfg_in.hold_dist_cm    = pwdata[9:0];
            REG_PAUSE_TIME: cfg_in.hold_len_ms     = pwdata[15:0];
            REG_MAX_RANGE:  cfg_in.max_range_cm    = pwdata[DIST_W-1:0];
            REG_US_PER_CM:  cfg_in.us_per_cm       = pwdata[7:0];
            REG_PING_TMO:   cfg_in.ping_timeout_us = pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PAUSE_DIST: prdata = {{22{cfg_ff.hold_dist_cm[9]}},
                                   cfg_ff.hold_dist_cm};
         REG_PAUSE_TIME: prdata = {16'd0, cfg_ff.hold_len_ms};
         REG_MAX_RANGE:  prdata = {{(32-DIST_W){1'b0}}, cfg_ff.max_range_cm};
         REG_US_PER_CM:  prdata = {24'd0, cfg_ff.us_per_cm};
         REG_PING_TMO:   prdata = {{(32-TICK_W){1'b0}}, cfg_ff.ping_timeout_us};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_dist_cm    <= 10'h3FF;
         cfg_ff.hold_len_ms     <= 16'd0;
         cfg_ff.max_range_cm    <= 9'd100;
         cfg_ff.us_per_cm       <= 8'd58;
         cfg_ff.ping_timeout_us <= 16'd6000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/rupc_ranger.sv */
module rupc_ranger #(
   parameter int TRIG_LOW_US  = 4,
   parameter int TRIG_HIGH_US = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     start_read,
   input  logic                     echo_level,
   input  rupc_pkg::cfg_type        cfg,
   output rupc_pkg::ranger_res_type res
);
   import rupc_pkg::*;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_TLOW  = 3'd1;
   localparam logic [2:0] PH_THIGH = 3'd2;
   localparam logic [2:0] PH_WAIT  = 3'd3;
   localparam logic [2:0] PH_MEAS  = 3'd4;

   logic [2:0]        phase_ff, phase_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in, ticks_inc;
   logic [7:0]        sub_ff, sub_in, sub_inc, upc;
   logic [DIST_W-1:0] cm_ff, cm_in, cm_inc;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              trig, done;
   logic [1:0]        status;

   assign ticks_inc = ticks_ff + TICK_W'(1);
   assign sub_inc   = sub_ff + 8'd1;
   assign cm_inc    = cm_ff + DIST_W'(1);
   assign upc       = (cfg.us_per_cm == 8'd0) ? 8'd1 : cfg.us_per_cm;

   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      sub_in   = sub_ff;
      cm_in    = cm_ff;
      dist_in  = dist_ff;
      trig     = 1'b0;
      done     = 1'b0;
      status   = ST_OK;

      case (phase_ff)
         PH_TLOW: begin
            ticks_in = ticks_inc;
            if (ticks_inc >= TICK_W'(TRIG_LOW_US)) begin
               phase_in = PH_THIGH;
               ticks_in = '0;
            end
         end
         PH_THIGH: begin
            trig     = 1'b1;
            ticks_in = ticks_inc;
            if (ticks_inc >= TICK_W'(TRIG_HIGH_US)) begin
               phase_in = PH_WAIT;
               ticks_in = '0;
            end
         end
         PH_WAIT: begin
            if (echo_level) begin
               // echo still high from an earlier ping on the first wait tick
               if (ticks_ff == '0) begin
                  done   = 1'b1;
                  status = ST_ECHO_HIGH;
               end else begin
                  phase_in = PH_MEAS;
                  ticks_in = '0;
                  sub_in   = '0;
                  cm_in    = '0;
               end
            end else begin
               ticks_in = ticks_inc;
               if (ticks_inc >= cfg.ping_timeout_us || ticks_inc == '0) begin
                  done   = 1'b1;
                  status = ST_NO_ECHO;
               end
            end
         end
         PH_MEAS: begin
            if (echo_level) begin
               if (sub_inc >= upc) begin
                  sub_in = '0;
                  cm_in  = cm_inc;
               end else begin
                  sub_in = sub_inc;
               end
               if (cm_in >= cfg.max_range_cm) begin
                  done   = 1'b1;
                  status = ST_ECHO_LONG;
               end
            end else begin
               done = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (start_read) begin
               phase_in = PH_TLOW;
               ticks_in = '0;
            end
         end
      endcase

      if (done) begin
         dist_in  = (status == ST_OK) ? cm_in : cfg.max_range_cm;
         phase_in = PH_IDLE;
         ticks_in = '0;
         sub_in   = '0;
         cm_in    = '0;
      end
   end

   assign res.trig     = trig;
   assign res.busy     = (phase_in != PH_IDLE);
   assign res.done     = done;
   assign res.status   = status;
   assign res.distance = dist_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ticks_ff <= '0;
         sub_ff   <= '0;
         cm_ff    <= '0;
         dist_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         sub_ff   <= sub_in;
         cm_ff    <= cm_in;
         dist_ff  <= dist_in;
      end
   end

endmodule

/* hdl/rupc_pause.sv */
module rupc_pause (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        done,
   input  logic [rupc_pkg::DIST_W-1:0] distance,
   input  logic [1:0]                  machine_state,
   input  rupc_pkg::cfg_type           cfg,
   output rupc_pkg::pause_res_type     res
);
   import rupc_pkg::*;

   logic                active_ff, active_in;
   logic                sched_ff, sched_in;
   logic [REMAIN_W-1:0] remain_ff, remain_in, load;
   logic                expired, near, hold_req, start_req;

   assign load    = REMAIN_W'(cfg.hold_len_ms) * REMAIN_W'(MS_TO_US);
   // timer must already read zero at the start of the tick
   assign expired = sched_ff && (remain_ff == '0);
   assign near    = !cfg.hold_dist_cm[9] &&
                    (distance <= cfg.hold_dist_cm[DIST_W-1:0]);

   always_comb begin
      active_in = active_ff;
      sched_in  = sched_ff;
      remain_in = (remain_ff == '0) ? '0 : remain_ff - REMAIN_W'(1);
      hold_req  = 1'b0;
      start_req = 1'b0;

      if (done) begin
         if (machine_state == MS_CYCLE) begin
            if (near) begin
               hold_req  = 1'b1;
               active_in = 1'b1;
            end
         end else if (machine_state == MS_HOLD) begin
            if (active_ff && !sched_ff) begin
               sched_in  = 1'b1;
               remain_in = load;
            end else if (active_ff && expired) begin
               sched_in = 1'b0;
               if (near) begin
                  sched_in  = 1'b1;
                  remain_in = load;
               end else begin
                  active_in = 1'b0;
                  start_req = 1'b1;
               end
            end
         end
      end
   end

   assign res.hold_req  = hold_req;
   assign res.start_req = start_req;
   assign res.active    = active_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         sched_ff  <= 1'b0;
         remain_ff <= '0;
      end else if (advance) begin
         active_ff <= active_in;
         sched_ff  <= sched_in;
         remain_ff <= remain_in;
      end
   end

endmodule

/* tb/sv/tb_ultrasonic_ranger_pause_control.sv */
module tb_ultrasonic_ranger_pause_control;
   timeunit 1ns;
   timeprecision 1ps;

   import rupc_pkg::*;

   localparam int TRIG_LOW_TICKS  = 4;
   localparam int TRIG_HIGH_TICKS = 10;

   localparam logic [1:0] MS_OTHER = 2'd0;
   localparam logic [1:0] MS_UNDEF = 2'd3;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
   localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
   localparam logic [2:0] PH_ECHO_WAIT = 3'd3;
   localparam logic [2:0] PH_ECHO_MEAS = 3'd4;

   typedef struct packed {
      ranger_res_type rng;
      pause_res_type  pz;
   } tick_result_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   rupc_req_if req_if ();
   rupc_rsp_if rsp_if ();

   ultrasonic_ranger_pause_control uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // ranger model state
   cfg_type             ranger_cfg;
   logic [2:0]          rg_phase;
   logic [TICK_W-1:0]   rg_ticks;
   logic [7:0]          rg_sub;
   logic [DIST_W-1:0]   rg_cm;
   logic [DIST_W-1:0]   last_dist;
   logic                pz_active;
   logic                pz_scheduled;
   logic [REMAIN_W-1:0] pz_remaining;

   tick_result_type pending_readouts[$];
   int           fail_count;
   int unsigned  ticks_sent;
   bit           tx_gaps_on;
   bit           rx_stalls_on;
   int           rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("ultrasonic_ranger_pause_control regression: fail");
      $finish;
   end

   function automatic logic obstacle_near();
      return !ranger_cfg.hold_dist_cm[9] &&
             ({1'b0, last_dist} <= ranger_cfg.hold_dist_cm);
   endfunction

   function automatic void arm_pause_timer();
      pz_scheduled = 1'b1;
      pz_remaining = REMAIN_W'(ranger_cfg.hold_len_ms * MS_TO_US);
   endfunction

   function automatic tick_result_type ranger_next_tick(logic start, logic echo,
                                                        logic [1:0] mstate);
      tick_result_type r;
      logic [7:0]   upc;
      logic         expired;
      r = '0;
      upc = (ranger_cfg.us_per_cm == 8'd0) ? 8'd1 : ranger_cfg.us_per_cm;
      expired = pz_scheduled && (pz_remaining == '0);
      if (pz_remaining != '0) pz_remaining = pz_remaining - REMAIN_W'(1);

      case (rg_phase)
         PH_TRIG_LOW: begin
            rg_ticks = rg_ticks + TICK_W'(1);
            if (rg_ticks >= TICK_W'(TRIG_LOW_TICKS)) begin
               rg_phase = PH_TRIG_HIGH;
               rg_ticks = '0;
            end
         end
         PH_TRIG_HIGH: begin
            r.rng.trig = 1'b1;
            rg_ticks = rg_ticks + TICK_W'(1);
            if (rg_ticks >= TICK_W'(TRIG_HIGH_TICKS)) begin
               rg_phase = PH_ECHO_WAIT;
               rg_ticks = '0;
            end
         end
         PH_ECHO_WAIT: begin
            if (echo) begin
               if (rg_ticks == '0) begin
                  r.rng.done   = 1'b1;
                  r.rng.status = ST_ECHO_HIGH;
               end else begin
                  rg_phase = PH_ECHO_MEAS;
                  rg_ticks = '0;
                  rg_sub   = '0;
                  rg_cm    = '0;
               end
            end else begin
               rg_ticks = rg_ticks + TICK_W'(1);
               // zero timeout or a wrapped count both end the wait
               if (rg_ticks >= ranger_cfg.ping_timeout_us || rg_ticks == '0) begin
                  r.rng.done   = 1'b1;
                  r.rng.status = ST_NO_ECHO;
               end
            end
         end
         PH_ECHO_MEAS: begin
            if (echo) begin
               rg_sub = rg_sub + 8'd1;
               if (rg_sub >= upc) begin
                  rg_sub = '0;
                  rg_cm  = rg_cm + DIST_W'(1);
               end
               if (rg_cm >= ranger_cfg.max_range_cm) begin
                  r.rng.done   = 1'b1;
                  r.rng.status = ST_ECHO_LONG;
               end
            end else begin
               r.rng.done = 1'b1;
            end
         end
         default: begin
            rg_phase = PH_IDLE;
            if (start) begin
               rg_phase = PH_TRIG_LOW;
               rg_ticks = '0;
            end
         end
      endcase

      if (r.rng.done) begin
         last_dist = (r.rng.status == ST_OK) ? rg_cm : ranger_cfg.max_range_cm;
         rg_phase  = PH_IDLE;
         rg_ticks  = '0;
         rg_sub    = '0;
         rg_cm     = '0;
         if (mstate == MS_CYCLE) begin
            if (obstacle_near()) begin
               r.pz.hold_req = 1'b1;
               pz_active     = 1'b1;
            end
         end else if (mstate == MS_HOLD) begin
            if (pz_active && !pz_scheduled) begin
               arm_pause_timer();
            end else if (pz_active && expired) begin
               pz_scheduled = 1'b0;
               if (obstacle_near()) begin
                  arm_pause_timer();
               end else begin
                  pz_active      = 1'b0;
                  r.pz.start_req = 1'b1;
               end
            end
         end
      end

      r.rng.busy     = (rg_phase != PH_IDLE);
      r.rng.distance = last_dist;
      r.pz.active    = pz_active;
      return r;
   endfunction

   function automatic void check_field(string name, logic [8:0] expv, logic [8:0] gotv);
      if (gotv !== expv) begin
         $error("%s: expected %0d, got %0d", name, expv, gotv);
         fail_count++;
      end
   endfunction

   // model update, register shadow and result compare, all on the same edge
   always @(posedge clock) begin
      tick_result_type exp_res;
      if (reset) begin
         ranger_cfg.hold_dist_cm    = 10'h3FF;
         ranger_cfg.hold_len_ms     = 16'd0;
         ranger_cfg.max_range_cm    = 9'd100;
         ranger_cfg.us_per_cm       = 8'd58;
         ranger_cfg.ping_timeout_us = 16'd6000;
         rg_phase     = PH_IDLE;
         rg_ticks     = '0;
         rg_sub       = '0;
         rg_cm        = '0;
         last_dist    = '0;
         pz_active    = 1'b0;
         pz_scheduled = 1'b0;
         pz_remaining = '0;
         pending_readouts.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_PAUSE_DIST: ranger_cfg.hold_dist_cm    = pwdata[9:0];
               REG_PAUSE_TIME: ranger_cfg.hold_len_ms     = pwdata[15:0];
               REG_MAX_RANGE:  ranger_cfg.max_range_cm    = pwdata[DIST_W-1:0];
               REG_US_PER_CM:  ranger_cfg.us_per_cm       = pwdata[7:0];
               REG_PING_TMO:   ranger_cfg.ping_timeout_us = pwdata[TICK_W-1:0];
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_readouts.size() == 0) begin
               $error("result beat with no expectation waiting");
               fail_count++;
            end else begin
               exp_res = pending_readouts.pop_front();
               check_field("trig_level", 9'(exp_res.rng.trig), 9'(rsp_if.trig_level));
               check_field("busy_res", 9'(exp_res.rng.busy), 9'(rsp_if.busy_res));
               check_field("reading_done", 9'(exp_res.rng.done), 9'(rsp_if.reading_done));
               check_field("distance_cm", exp_res.rng.distance, rsp_if.distance_cm);
               check_field("read_status", 9'(exp_res.rng.status), 9'(rsp_if.read_status));
               check_field("feed_hold_request", 9'(exp_res.pz.hold_req),
                           9'(rsp_if.feed_hold_request));
               check_field("cycle_start_request", 9'(exp_res.pz.start_req),
                           9'(rsp_if.cycle_start_request));
               check_field("pause_in_effect", 9'(exp_res.pz.active),
                           9'(rsp_if.pause_in_effect));
            end
         end
         if (req_if.valid && req_if.ready)
            pending_readouts.push_back(ranger_next_tick(req_if.start_read,
                                                        req_if.echo_level,
                                                        req_if.machine_state));
      end
   end

   // result side: random stalls, plus a counted hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_if.ready <= !(rx_stalls_on && $urandom_range(0, 99) < 17);
         end
      end
   end

   task automatic send_tick(logic start, logic echo, logic [1:0] mstate);
      while (tx_gaps_on && $urandom_range(0, 99) < 17) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.start_read    <= start;
      req_if.echo_level    <= echo;
      req_if.machine_state <= mstate;
      do @(posedge clock); while (!req_if.ready);
      ticks_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // drain, then finish any reading in flight so registers change only while idle
   task automatic quiesce();
      wait_drained();
      while (rg_phase != PH_IDLE) begin
         send_tick(1'b0, rg_phase == PH_ECHO_WAIT, MS_OTHER);
         wait_drained();
      end
   endtask

   task automatic apb_cycle(logic wr, logic [2:0] idx, logic [31:0] data,
                            output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reg(logic [2:0] idx, logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] rd;
      case (idx)
         REG_PAUSE_DIST: mask = 32'h3FF;
         REG_PAUSE_TIME: mask = 32'hFFFF;
         REG_MAX_RANGE:  mask = 32'h1FF;
         REG_US_PER_CM:  mask = 32'hFF;
         default:        mask = 32'hFFFF;
      endcase
      apb_cycle(1'b1, idx, value, rd);
      apb_cycle(1'b0, idx, 32'd0, rd);
      if ((rd & mask) !== (value & mask)) begin
         $error("register %0d readback: expected %0h, got %0h", idx, value & mask,
                rd & mask);
         fail_count++;
      end
   endtask

   task automatic set_all_regs(logic [31:0] pdist, logic [31:0] ptime,
                               logic [31:0] maxr, logic [31:0] upc, logic [31:0] ptmo);
      quiesce();
      set_reg(REG_PAUSE_DIST, pdist);
      set_reg(REG_PAUSE_TIME, ptime);
      set_reg(REG_MAX_RANGE, maxr);
      set_reg(REG_US_PER_CM, upc);
      set_reg(REG_PING_TMO, ptmo);
   endtask

   // start tick, trigger pulse, d quiet wait ticks, w echo-high ticks, echo falls
   task automatic fire_reading(int d, int w, logic [1:0] mstate, bit poke_start);
      send_tick(1'b1, 1'b0, mstate);
      repeat (TRIG_LOW_TICKS + TRIG_HIGH_TICKS)
         send_tick(poke_start ? 1'($urandom_range(0, 1)) : 1'b0,
                   1'($urandom_range(0, 1)), mstate);
      repeat (d) send_tick(1'b0, 1'b0, mstate);
      repeat (w) send_tick(1'b0, 1'b1, mstate);
      send_tick(1'b0, 1'b0, mstate);
   endtask

   function automatic logic [1:0] pick_machine_state();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return MS_CYCLE;
      if (r < 8) return MS_HOLD;
      return (r == 8) ? MS_OTHER : MS_UNDEF;
   endfunction

   task automatic random_readings(int unsigned budget, int max_delay, int max_width);
      int unsigned first;
      logic [1:0]  ms;
      first = ticks_sent;
      while (ticks_sent - first < budget) begin
         if ($urandom_range(0, 99) < 80) begin
            ms = pick_machine_state();
            fire_reading($urandom_range(0, max_delay), $urandom_range(0, max_width), ms,
                         $urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 3))
               send_tick(1'b0, 1'($urandom_range(0, 1)), ms);
         end else begin
            repeat ($urandom_range(1, 12))
               send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)));
         end
      end
   endtask

   task automatic test_default_config();
      fire_reading(0, 3, MS_CYCLE, 0);      // echo already high: error, max range
      fire_reading(2, 117, MS_HOLD, 0);     // 116 us at 58 us/cm
   endtask

   task automatic test_status_codes();
      set_all_regs(32'd400, 32'd0, 32'd3, 32'd1, 32'd4);
      fire_reading(0, 1, MS_CYCLE, 0);
      fire_reading(6, 0, MS_CYCLE, 0);      // echo never rises
      fire_reading(1, 2, MS_OTHER, 0);
      fire_reading(1, 6, MS_UNDEF, 0);      // echo too long
      fire_reading(2, 3, MS_CYCLE, 1);      // start pokes while busy
      quiesce();
      set_reg(REG_PING_TMO, 32'd0);
      fire_reading(1, 2, MS_HOLD, 0);
      fire_reading(0, 2, MS_HOLD, 0);
   endtask

   task automatic test_count_extremes();
      set_all_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd2);
      fire_reading(1, 2, MS_CYCLE, 0);      // zero range ends on first measured high tick
      quiesce();
      set_reg(REG_MAX_RANGE, 32'd2);
      fire_reading(1, 2, MS_CYCLE, 0);
      fire_reading(1, 3, MS_CYCLE, 0);
      quiesce();
      set_reg(REG_MAX_RANGE, 32'd1);
      set_reg(REG_US_PER_CM, 32'd255);
      set_reg(REG_PING_TMO, 32'd300);
      fire_reading(1, 257, MS_CYCLE, 0);
      fire_reading(1, 200, MS_CYCLE, 0);
   endtask

   task automatic test_pause_sequence();
      set_all_regs(32'd400, 32'd0, 32'd20, 32'd1, 32'd10);
      fire_reading(1, 5, MS_HOLD, 0);       // no pause yet
      fire_reading(1, 5, MS_CYCLE, 0);      // obstacle: hold
      fire_reading(1, 5, MS_HOLD, 0);       // timer armed
      fire_reading(1, 5, MS_HOLD, 0);       // expired, still near: rearm
      fire_reading(1, 5, MS_OTHER, 0);
      fire_reading(1, 5, MS_UNDEF, 0);
      quiesce();
      set_reg(REG_PAUSE_DIST, 32'd2);
      fire_reading(1, 6, MS_HOLD, 0);       // clear: resume
      quiesce();
      set_reg(REG_PAUSE_DIST, 32'hFFFF_FFFF);
      fire_reading(1, 1, MS_CYCLE, 0);
      quiesce();
      set_reg(REG_PAUSE_DIST, 32'hFFFF_FE00);
      fire_reading(1, 1, MS_CYCLE, 0);
      quiesce();
      set_reg(REG_PAUSE_DIST, 32'd0);
      fire_reading(1, 1, MS_CYCLE, 0);
   endtask

   task automatic test_random_steady();
      set_all_regs(32'd5, 32'd0, 32'd10, 32'd1, 32'd12);
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;
      random_readings(200, 14, 12);
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   task automatic test_backpressure();
      set_all_regs(32'd400, 32'd1, 32'd6, 32'd3, 32'd5);
      rsp_hold_cycles = 60;
      random_readings(260, 6, 22);
   endtask

   task automatic test_random_wide();
      set_all_regs(32'd511, 32'd2, 32'd400, 32'd2, 32'd30);
      random_readings(180, 35, 30);
      set_all_regs(32'd3, 32'd65535, 32'd9, 32'd1, 32'd65535);
      random_readings(170, 10, 12);
   endtask

   initial begin
      fail_count      = 0;
      ticks_sent      = 0;
      tx_gaps_on      = 1'b1;
      rx_stalls_on    = 1'b1;
      rsp_hold_cycles = 0;
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.start_read    <= 1'b0;
      req_if.echo_level    <= 1'b0;
      req_if.machine_state <= MS_OTHER;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_config();
      test_status_codes();
      test_count_extremes();
      test_pause_sequence();
      test_random_steady();
      test_backpressure();
      test_random_wide();

      wait_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("ultrasonic_ranger_pause_control regression: pass");
      else
         $display("ultrasonic_ranger_pause_control regression: fail");
      $finish;
   end

endmodule

/* files.f */
hdl/rupc_pkg.sv
hdl/rupc_if.sv
hdl/rupc_csr.sv
hdl/rupc_ranger.sv
hdl/rupc_pause.sv
hdl/ultrasonic_ranger_pause_control.sv
tb/sv/tb_ultrasonic_ranger_pause_control.sv
